// ===== hw/rtl/lmsd_pkg.sv =====
// Package for the LED matrix scan driver: payload structs, register map,
// opcode codes and fixed field widths.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package lmsd_pkg;

    localparam int CH_W       = 8;
    localparam int PIXEL_W    = 3 * CH_W;
    localparam int COLOUR_W   = 6;
    localparam int ROW_ADDR_W = 4;
    localparam int TPU_W      = 10;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TPU_W-1:0] TPU_RESET = 10'd1;

    // Register index taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_TICKS_PER_UNIT = 1'b0;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [5:0]        pixel_x;
        logic [4:0]        pixel_y;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
    } in_item_t;

    typedef struct packed {
        logic [COLOUR_W-1:0]   colour_bits;
        logic                  shift_clock;
        logic [ROW_ADDR_W-1:0] row_address;
        logic                  latch;
        logic                  output_enable_n;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lmsd_stream_if.sv =====
// Valid/ready stream interface used for the command and pin-state channels.
// Payload type is a parameter; the block binds it to structs from lmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lmsd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/led_matrix_scan_driver.sv =====
// A time tick's pin state goes through the stage 1 registers to the output register.
// Throughput: one transaction per cycle, ticks and pixel writes alike, unless the output
// stalls; the frame store has one write and one read port per half, so a write and a
// tick read never contend. Reset: scan state clears at once; a clearing pass then zeroes
// the frame store, one address per cycle, over all MEM_DEPTH addresses (1024 by default).
// No input is taken during that pass; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_scan_driver #(
    parameter int PANEL_WIDTH = 64,
    parameter int ROW_PAIRS   = 16,
    parameter int PLANE_COUNT = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lmsd_stream_if.sink                          in_stream,
    lmsd_stream_if.source                        out_stream,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lmsd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lmsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lmsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import lmsd_pkg::*;

    localparam int COL_W     = $clog2(PANEL_WIDTH);
    localparam int ROW_W     = $clog2(ROW_PAIRS);
    localparam int PLANE_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int DISP_W    = TPU_W + PLANE_COUNT - 1;

    typedef enum logic [1:0] {
        PH_SHIFT,
        PH_LATCH,
        PH_DISPLAY
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [PLANE_W-1:0]    plane;
        logic [ROW_ADDR_W-1:0] hold;
    } tick_meta_t;

    // ---------------- configuration ----------------
    logic [TPU_W-1:0] tpu_reg;
    logic             cfg_write;
    logic             cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[APB_ADDR_W-1:2] == REG_TICKS_PER_UNIT);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? APB_DATA_W'(tpu_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TPU_RESET;
        end
        else if (cfg_write)
        begin
            tpu_reg <= pwdata[TPU_W-1:0];
        end
    end

    // ---------------- scan and pipeline state ----------------
    phase_t                phase_reg, phase_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic [DISP_W-1:0]     disp_reg, disp_next;
    logic [ROW_ADDR_W-1:0] hold_reg, hold_next;
    logic                  clear_reg, clear_next;
    logic [ADDR_W-1:0]     clear_addr_reg, clear_addr_next;
    logic                  s1_valid_reg, s1_valid_next;
    tick_meta_t            s1_meta_reg, s1_meta_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    in_item_t          cmd;
    logic              in_fire;
    logic              tick_fire;
    logic              write_fire;
    logic              s1_advance;
    logic [DISP_W:0]   disp_inc;
    logic [DISP_W:0]   disp_len;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [PLANE_W:0]  plane_inc;

    assign cmd        = in_stream.payload;
    assign s1_advance = s1_valid_reg && (out_stream.ready || !out_valid_reg);
    assign in_stream.ready = !clear_reg && (!s1_valid_reg || s1_advance);
    assign in_fire    = in_stream.valid && in_stream.ready;
    assign tick_fire  = in_fire && (cmd.opcode == OP_TICK);
    assign write_fire = in_fire && (cmd.opcode == OP_WRITE);

    assign disp_inc  = (DISP_W + 1)'(disp_reg) + 1'b1;
    assign disp_len  = (DISP_W + 1)'(tpu_reg) << plane_reg;
    assign col_inc   = (COL_W + 1)'(col_reg) + 1'b1;
    assign row_inc   = (ROW_W + 1)'(row_reg) + 1'b1;
    assign plane_inc = (PLANE_W + 1)'(plane_reg) + 1'b1;

    // ---------------- frame store ----------------
    logic [PIXEL_W-1:0] upper_mem [MEM_DEPTH];
    logic [PIXEL_W-1:0] lower_mem [MEM_DEPTH];
    logic [PIXEL_W-1:0] upper_rd_reg;
    logic [PIXEL_W-1:0] lower_rd_reg;

    logic [8:0]         wr_x_ext;
    logic [6:0]         wr_y_ext;
    logic [6:0]         wr_y_low;
    logic               wr_in_panel;
    logic               wr_upper;
    logic [ROW_W-1:0]   wr_row;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               wr_upper_en;
    logic               wr_lower_en;
    logic [ADDR_W-1:0]  rd_addr;

    assign wr_x_ext    = 9'(cmd.pixel_x);
    assign wr_y_ext    = 7'(cmd.pixel_y);
    assign wr_y_low    = wr_y_ext - 7'(ROW_PAIRS);
    assign wr_in_panel = (wr_x_ext < 9'(PANEL_WIDTH)) && (wr_y_ext < 7'(2 * ROW_PAIRS));
    assign wr_upper    = (wr_y_ext < 7'(ROW_PAIRS));
    assign wr_row      = wr_upper ? wr_y_ext[ROW_W-1:0] : wr_y_low[ROW_W-1:0];
    assign wr_addr     = clear_reg ? clear_addr_reg : {wr_row, COL_W'(wr_x_ext)};
    assign wr_data     = clear_reg ? '0 : {cmd.red, cmd.green, cmd.blue};
    assign wr_upper_en = clear_reg || (write_fire && wr_in_panel && wr_upper);
    assign wr_lower_en = clear_reg || (write_fire && wr_in_panel && !wr_upper);
    assign rd_addr     = {row_reg, col_reg};

    always_ff @(posedge clk)
    begin
        if (wr_upper_en)
        begin
            upper_mem[wr_addr] <= wr_data;
        end
        if (wr_lower_en)
        begin
            lower_mem[wr_addr] <= wr_data;
        end
        // Hold read data while the tick waits in stage 1
        if (tick_fire)
        begin
            upper_rd_reg <= upper_mem[rd_addr];
            lower_rd_reg <= lower_mem[rd_addr];
        end
    end

    // ---------------- next-state logic ----------------
    always_comb
    begin
        phase_next      = phase_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        plane_next      = plane_reg;
        disp_next       = disp_reg;
        hold_next       = hold_reg;
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;

        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(MEM_DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end

        if (tick_fire)
        begin
            case (phase_reg)
                PH_LATCH:
                begin
                    hold_next  = ROW_ADDR_W'(row_reg);
                    phase_next = PH_DISPLAY;
                    disp_next  = '0;
                end
                PH_DISPLAY:
                begin
                    if (disp_inc >= disp_len)
                    begin
                        disp_next  = '0;
                        col_next   = '0;
                        phase_next = PH_SHIFT;
                        if (row_inc >= (ROW_W + 1)'(ROW_PAIRS))
                        begin
                            row_next = '0;
                            if (plane_inc >= (PLANE_W + 1)'(PLANE_COUNT))
                            begin
                                plane_next = '0;
                            end
                            else
                            begin
                                plane_next = plane_inc[PLANE_W-1:0];
                            end
                        end
                        else
                        begin
                            row_next = row_inc[ROW_W-1:0];
                        end
                    end
                    else
                    begin
                        disp_next = disp_inc[DISP_W-1:0];
                    end
                end
                PH_SHIFT:
                begin
                    if (col_inc >= (COL_W + 1)'(PANEL_WIDTH))
                    begin
                        col_next   = '0;
                        phase_next = PH_LATCH;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                end
                default:
                begin
                    phase_next = PH_SHIFT;
                end
            endcase
        end

        s1_meta_next.phase = phase_reg;
        s1_meta_next.plane = plane_reg;
        s1_meta_next.hold  = hold_next;

        if (tick_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Stage 2: threshold compare against the stored pixels
    logic [CH_W-1:0]     thr;
    logic [2:0]          upper_bits;
    logic [2:0]          lower_bits;

    assign thr = CH_W'(1) << s1_meta_reg.plane;
    assign upper_bits = {upper_rd_reg[CH_W-1:0] > thr,
                         upper_rd_reg[2*CH_W-1:CH_W] > thr,
                         upper_rd_reg[3*CH_W-1:2*CH_W] > thr};
    assign lower_bits = {lower_rd_reg[CH_W-1:0] > thr,
                         lower_rd_reg[2*CH_W-1:CH_W] > thr,
                         lower_rd_reg[3*CH_W-1:2*CH_W] > thr};

    always_comb
    begin
        out_item_next.colour_bits     = (s1_meta_reg.phase == PH_SHIFT) ?
                                        {lower_bits, upper_bits} : '0;
        out_item_next.shift_clock     = (s1_meta_reg.phase == PH_SHIFT);
        out_item_next.row_address     = s1_meta_reg.hold;
        out_item_next.latch           = (s1_meta_reg.phase == PH_LATCH);
        out_item_next.output_enable_n = (s1_meta_reg.phase != PH_DISPLAY);

        if (s1_valid_reg)
        begin
            out_valid_next = s1_advance ? 1'b1 : out_valid_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_stream.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SHIFT;
            col_reg        <= '0;
            row_reg        <= '0;
            plane_reg      <= '0;
            disp_reg       <= '0;
            hold_reg       <= '0;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            plane_reg      <= plane_next;
            disp_reg       <= disp_next;
            hold_reg       <= hold_next;
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            s1_meta_reg <= s1_meta_next;
        end
        if (s1_advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_stream.valid   = out_valid_reg;
    assign out_stream.payload = out_item_reg;

    // ---------------- assertions ----------------
    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !in_stream.ready)
        else $error("input taken during frame store clearing");

    a_display_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DISPLAY) |-> (disp_reg == '0))
        else $error("display count not cleared outside display phase");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(PANEL_WIDTH - 1) || col_reg == COL_W'(PANEL_WIDTH - 1))
        else $error("column count beyond panel width");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_stream.ready) |=> s1_valid_reg)
        else $error("stage 1 tick lost during output stall");

    a_latch_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.latch) |->
        (out_item_reg.output_enable_n && !out_item_reg.shift_clock
         && out_item_reg.colour_bits == '0))
        else $error("latch tick drives shift, enable or colour");

endmodule

`default_nettype wire
